/* design/petn_pkg.sv */
package petn_pkg;

  // Default widths: signed Q8.16 coordinates
  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

endpackage

/* design/polygon_edge_tangent_normal_unit.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  x_coord, y_coord, last_point
// result    out        out_valid/out_stall  edge_length, tangent_x, tangent_y,
//                                           normal_x, normal_y, zero_length,
//                                           closing_edge
//
// Each edge runs from acceptance to the output register through two squarings
// on one multiplier and an add, then the square root and two divisions, one
// bit per cycle through the shared subtract unit. A new request is taken only
// once the sequencer is back in idle. A last vertex ends with the closing edge.
// A non-last first vertex is only stored and yields no edge. in_stall is
// high whenever the sequencer is busy. A finished edge waits in the output
// register; rst (synchronous) clears control state and the held vertices.
module polygon_edge_tangent_normal_unit #(
  parameter int COORD_BITS = petn_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = petn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request in
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] x_coord,
  input  logic signed [COORD_BITS-1:0] y_coord,
  input  logic                         last_point,
  // result out
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [COORD_BITS:0]   edge_length,
  output logic signed [FRAC_BITS+1:0]  tangent_x,
  output logic signed [FRAC_BITS+1:0]  tangent_y,
  output logic signed [FRAC_BITS+1:0]  normal_x,
  output logic signed [FRAC_BITS+1:0]  normal_y,
  output logic                         zero_length,
  output logic                         closing_edge
);

  localparam int CB       = COORD_BITS;
  localparam int FB       = FRAC_BITS;
  localparam int RW       = 2 * CB + 2;          // radicand width
  localparam int SW       = CB + 3;              // shared unit width
  localparam int ITER_MAX = (CB > FB) ? CB : FB;
  localparam int CNT_W    = $clog2(ITER_MAX + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_X, S_MUL_Y, S_ADD, S_SQRT, S_DIV_X, S_DIV_Y, S_DONE
  } state_t;

  state_t state;

  // vertex memory
  logic [CB-1:0] first_x, first_y, prev_x, prev_y;
  logic          have_vertex;
  logic          close_pending;   // closing edge still to run
  logic          cur_closing;     // edge in flight is the closing one

  // edge datapath
  logic [CB:0]    dx, dy;         // signed differences
  logic [RW-1:0]  prod, rad;
  logic [SW-1:0]  rem;
  logic [CB:0]    root;
  logic [FB:0]    quo;
  logic [FB+1:0]  tan_x, tan_y;
  logic [CNT_W-1:0] cnt;

  logic [CB:0]    ax, ay, mul_in;
  logic [RW-1:0]  sq;
  logic [SW-1:0]  alu_a, alu_b, alu_diff;
  logic           alu_ge;
  logic           div_first;
  logic [FB:0]    quo_fin;
  logic [CB:0]    acc_dx, acc_dy;
  logic           in_acc, out_free, out_load;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign out_load = (state == S_DONE) & out_free;

  assign ax = dx[CB] ? (~dx + 1'b1) : dx;
  assign ay = dy[CB] ? (~dy + 1'b1) : dy;

  // differences against the previous vertex, sign-extended
  assign acc_dx = {x_coord[CB-1], x_coord} - {prev_x[CB-1], prev_x};
  assign acc_dy = {y_coord[CB-1], y_coord} - {prev_y[CB-1], prev_y};

  // single squaring multiplier, result registered in prod
  assign mul_in = (state == S_MUL_X) ? ax : ay;
  assign sq     = {{(CB+1){1'b0}}, mul_in} * {{(CB+1){1'b0}}, mul_in};

  assign div_first = (cnt == CNT_W'(FB));

  // operand select for the shared unit
  always_comb begin
    if (state == S_SQRT) begin
      alu_a = {rem[SW-3:0], rad[RW-1:RW-2]};
      alu_b = {root, 2'b01};
    end else begin
      alu_a = div_first ? {2'b00, rem[CB:0]} : {1'b0, rem[CB:0], 1'b0};
      alu_b = {2'b00, root};
    end
  end

  petn_alu #(.W(SW)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  assign quo_fin = {quo[FB-1:0], alu_ge};

  function automatic logic [FB+1:0] apply_sign(input logic neg, input logic [FB:0] mag);
    logic [FB+1:0] ext;
    ext = {1'b0, mag};
    return neg ? (~ext + 1'b1) : ext;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      have_vertex   <= 1'b0;
      close_pending <= 1'b0;
      cur_closing   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            prev_x <= x_coord;
            prev_y <= y_coord;
            if (!have_vertex) begin
              first_x     <= x_coord;
              first_y     <= y_coord;
              have_vertex <= ~last_point;
              if (last_point) begin
                // lone vertex: closing edge to itself
                dx            <= '0;
                dy            <= '0;
                cur_closing   <= 1'b1;
                close_pending <= 1'b0;
                state         <= S_MUL_X;
              end
            end else begin
              dx            <= acc_dx;
              dy            <= acc_dy;
              cur_closing   <= 1'b0;
              close_pending <= last_point;
              if (last_point) begin
                have_vertex <= 1'b0;
              end
              state <= S_MUL_X;
            end
          end
        end
        S_MUL_X: begin
          prod  <= sq;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          rad   <= prod;
          prod  <= sq;
          state <= S_ADD;
        end
        S_ADD: begin
          rad   <= rad + prod;
          rem   <= '0;
          root  <= '0;
          cnt   <= CNT_W'(CB);
          state <= S_SQRT;
        end
        S_SQRT: begin
          // one root bit per cycle, two radicand bits in
          root <= {root[CB-1:0], alu_ge};
          rad  <= {rad[RW-3:0], 2'b00};
          if (cnt == '0) begin
            rem   <= {2'b00, ax};
            quo   <= '0;
            cnt   <= CNT_W'(FB);
            state <= S_DIV_X;
          end else begin
            rem <= alu_ge ? alu_diff : alu_a;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_X: begin
          if (cnt == '0) begin
            tan_x <= apply_sign(dx[CB], quo_fin);
            rem   <= {2'b00, ay};
            quo   <= '0;
            cnt   <= CNT_W'(FB);
            state <= S_DIV_Y;
          end else begin
            quo <= quo_fin;
            rem <= alu_ge ? alu_diff : alu_a;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_Y: begin
          quo <= quo_fin;
          if (cnt == '0) begin
            tan_y <= apply_sign(dy[CB], quo_fin);
            state <= S_DONE;
          end else begin
            rem <= alu_ge ? alu_diff : alu_a;
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            edge_length  <= root;
            zero_length  <= (root == '0);
            closing_edge <= cur_closing;
            if (root == '0) begin
              tangent_x <= '0;
              tangent_y <= '0;
              normal_x  <= '0;
              normal_y  <= '0;
            end else begin
              tangent_x <= tan_x;
              tangent_y <= tan_y;
              normal_x  <= tan_y;
              normal_y  <= ~tan_x + 1'b1;
            end
            if (close_pending) begin
              // prev holds the last vertex by now
              dx            <= {first_x[CB-1], first_x} - {prev_x[CB-1], prev_x};
              dy            <= {first_y[CB-1], first_y} - {prev_y[CB-1], prev_y};
              cur_closing   <= 1'b1;
              close_pending <= 1'b0;
              state         <= S_MUL_X;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/petn_alu.sv */
// Shared compare/subtract unit: diff = a - b, ge = (a >= b).
module petn_alu #(
  parameter int W = petn_pkg::COORD_BITS_DEF + 3
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int CB = petn_pkg::COORD_BITS_DEF;
  localparam int FB = petn_pkg::FRAC_BITS_DEF;

  // Timeout: generous for ~2000 requests, their edges and the stalls.
  localparam int CYCLE_LIMIT  = 1_500_000;
  // Wait after all results are in, before the final queue check.
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD    = 600;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [FB+1:0] unit_t;

  localparam coord_t COORD_MIN = coord_t'(-(2 ** (CB - 1)));
  localparam coord_t COORD_MAX = coord_t'(2 ** (CB - 1) - 1);
  localparam coord_t COORD_ONE = coord_t'(1 << FB);

  // One expected edge result
  typedef struct {
    logic [CB:0] length;
    unit_t       tan_x;
    unit_t       tan_y;
    unit_t       nrm_x;
    unit_t       nrm_y;
    logic        zero_len;
    logic        closing;
  } edge_rec_t;

  logic          clk;
  logic          rst        = 1'b1;
  logic          in_valid   = 1'b0;
  logic          in_stall;
  coord_t        x_coord    = '0;
  coord_t        y_coord    = '0;
  logic          last_point = 1'b0;
  logic          out_valid;
  logic          out_stall  = 1'b0;
  logic [CB:0]   edge_length;
  unit_t         tangent_x;
  unit_t         tangent_y;
  unit_t         normal_x;
  unit_t         normal_y;
  logic          zero_length;
  logic          closing_edge;

  polygon_edge_tangent_normal_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .edge_length  (edge_length),
    .tangent_x    (tangent_x),
    .tangent_y    (tangent_y),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .zero_length  (zero_length),
    .closing_edge (closing_edge)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle rates in percent, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by a test to ask the result side for one long hold-off
  int hold_request  = 0;

  int mismatch_count  = 0;
  int vertices_sent   = 0;
  int edges_checked   = 0;
  int closing_checked = 0;
  int zero_checked    = 0;
  int cycle_count     = 0;

  // Polygon tracking state of the predictor
  coord_t poly_first_x = '0;
  coord_t poly_first_y = '0;
  coord_t poly_prev_x  = '0;
  coord_t poly_prev_y  = '0;
  bit     vertex_held  = 1'b0;

  edge_rec_t pending_edges[$];

  // ---------------------------------------------------------------------------
  // Edge arithmetic
  // ---------------------------------------------------------------------------

  // trunc(d * 2^FB / len) toward zero, kept at the Q2.16 width
  function automatic unit_t scaled_ratio(longint d, longint len);
    longint q;
    q = ((d < 0) ? -d : d) << FB;
    q = q / len;
    if (d < 0) q = -q;
    return q[FB+1:0];
  endfunction

  // Full result for the edge from (px,py) to (qx,qy). The squared length
  // stays below 2^50, so 64-bit math is exact; the root is built bit by bit
  // from the top so it is the floor square root.
  function automatic edge_rec_t edge_between(coord_t px, coord_t py,
                                             coord_t qx, coord_t qy,
                                             bit closing);
    longint    dx;
    longint    dy;
    longint    sum_sq;
    longint    root;
    longint    trial;
    edge_rec_t r;
    dx     = longint'(qx) - longint'(px);
    dy     = longint'(qy) - longint'(py);
    sum_sq = dx * dx + dy * dy;
    root   = 0;
    for (int b = CB; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    r.length   = root[CB:0];
    r.zero_len = (root == 0);
    r.closing  = closing;
    // zero-length edge: tangent and normal forced to zero
    r.tan_x    = (root == 0) ? unit_t'(0) : scaled_ratio(dx, root);
    r.tan_y    = (root == 0) ? unit_t'(0) : scaled_ratio(dy, root);
    r.nrm_x    = r.tan_y;
    r.nrm_y    = -r.tan_x;
    return r;
  endfunction

  // Update polygon state for one accepted vertex and queue its edges
  task automatic accept_vertex(coord_t x, coord_t y, bit last);
    if (!vertex_held) begin
      // first vertex of a polygon: no edge yet
      poly_first_x = x;
      poly_first_y = y;
      vertex_held  = 1'b1;
    end else begin
      pending_edges.push_back(edge_between(poly_prev_x, poly_prev_y, x, y, 1'b0));
    end
    poly_prev_x = x;
    poly_prev_y = y;
    if (last) begin
      // closing edge back to the first vertex, then start a new polygon
      pending_edges.push_back(edge_between(x, y, poly_first_x, poly_first_y, 1'b1));
      vertex_held = 1'b0;
    end
    vertices_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one vertex; valid is left high after acceptance so back-to-back
  // requests never see valid drop and rise in the same step.
  task automatic send_vertex(coord_t x, coord_t y, bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    x_coord    <= x;
    y_coord    <= y;
    last_point <= last;
    do @(posedge clk); while (in_stall);
    accept_vertex(x, y, last);
  endtask

  // Drop valid and wait until every queued edge has been checked
  task automatic hold_until_results_in();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_edges.size() != 0);
  endtask

  // Next coordinate of a random walk: full range, a step of random scale,
  // the same value (axis-aligned edge), a range limit, zero or minus one
  function automatic coord_t next_coord(coord_t from);
    int          pick;
    int unsigned span;
    pick = $urandom_range(9);
    if (pick < 4) return coord_t'($urandom);
    if (pick < 8) begin
      span = 1 << $urandom_range(20);
      return from + coord_t'($urandom_range(2 * span) - span);
    end
    if (pick == 8) return from;
    case ($urandom_range(3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return coord_t'(0);
      default: return coord_t'(-1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls; a long hold-off is counted down here when asked for
  int held_cycles = 0;
  always @(posedge clk) begin
    if (hold_request != 0) begin
      held_cycles  = hold_request;
      hold_request = 0;
    end
    if (held_cycles > 0) begin
      out_stall   <= 1'b1;
      held_cycles = held_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each accepted result against the oldest queued edge
  always @(posedge clk) begin
    edge_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        $error("unexpected result: edge_length %0d closing_edge %0b",
               edge_length, closing_edge);
        mismatch_count++;
      end else begin
        want = pending_edges.pop_front();
        check_field("edge_length",  want.length,   edge_length);
        check_field("tangent_x",    want.tan_x,    tangent_x);
        check_field("tangent_y",    want.tan_y,    tangent_y);
        check_field("normal_x",     want.nrm_x,    normal_x);
        check_field("normal_y",     want.nrm_y,    normal_y);
        check_field("zero_length",  want.zero_len, zero_length);
        check_field("closing_edge", want.closing,  closing_edge);
        edges_checked++;
        if (want.closing)  closing_checked++;
        if (want.zero_len) zero_checked++;
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d edges outstanding",
             cycle_count, pending_edges.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single-vertex polygons: one zero-length closing edge each
  task automatic test_single_vertex();
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    send_vertex(coord_t'(0), coord_t'(0), 1'b1);
  endtask

  // Corners of the coordinate range: longest diagonal and full-span sides
  task automatic test_extreme_span();
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
  endtask

  // Unit square: tangents of exactly +1.0 and -1.0 on each axis
  task automatic test_axis_square();
    send_vertex(coord_t'(0), coord_t'(0), 1'b0);
    send_vertex(COORD_ONE,   coord_t'(0), 1'b0);
    send_vertex(COORD_ONE,   COORD_ONE,   1'b0);
    send_vertex(coord_t'(0), COORD_ONE,   1'b1);
  endtask

  // Repeated vertices: zero-length edges in the middle of a polygon
  task automatic test_repeated_vertex();
    send_vertex(coord_t'(5),       coord_t'(-7),     1'b0);
    send_vertex(coord_t'(5),       coord_t'(-7),     1'b0);
    send_vertex(coord_t'(-300000), coord_t'(120000), 1'b0);
    send_vertex(coord_t'(-300000), coord_t'(120000), 1'b1);
  endtask

  // One-LSB diagonal steps, then a two-LSB closing edge: length 1 or 2, floor root below |dx|+|dy| on the diagonals
  task automatic test_unit_steps();
    send_vertex(coord_t'(-1), coord_t'(-1), 1'b0);
    send_vertex(coord_t'(0),  coord_t'(0),  1'b0);
    send_vertex(coord_t'(1),  coord_t'(-1), 1'b1);
  endtask

  // Random polygons of 1..9 vertices, always closed
  task automatic test_random_polygons(int count);
    int     sent;
    int     nv;
    coord_t gx;
    coord_t gy;
    sent = 0;
    gx   = '0;
    gy   = '0;
    while (sent < count) begin
      nv = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 9);
      for (int i = 0; i < nv; i++) begin
        // occasionally repeat the previous vertex for a zero-length edge
        if (i == 0 || $urandom_range(11) != 0) begin
          gx = next_coord(gx);
          gy = next_coord(gy);
        end
        send_vertex(gx, gy, i == nv - 1);
      end
      sent += nv;
    end
  endtask

  // Result side holds off for a long stretch while requests keep coming,
  // so the output register and the sequencer both fill and in_stall rises
  task automatic test_output_hold_off();
    coord_t gx;
    coord_t gy;
    gx = '0;
    gy = '0;
    hold_request = LONG_HOLD;
    for (int i = 0; i < 12; i++) begin
      gx = next_coord(gx);
      gy = next_coord(gy);
      send_vertex(gx, gy, i == 11);
    end
    hold_until_results_in();
  endtask

  // Request side pauses mid-polygon until all results are in; the held
  // first and previous vertices must survive the pause
  task automatic test_sender_pause();
    send_vertex(coord_t'(1000),    coord_t'(2000),   1'b0);
    send_vertex(coord_t'(-70000),  coord_t'(33333),  1'b0);
    send_vertex(coord_t'(123456),  coord_t'(-98765), 1'b0);
    hold_until_results_in();
    send_vertex(COORD_MAX,         coord_t'(0),      1'b0);
    send_vertex(coord_t'(-4),      COORD_MIN,        1'b1);
    hold_until_results_in();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: sparse request gaps, heavy result stalls
    send_idle_pct = 9;
    recv_idle_pct = 77;
    test_single_vertex();
    test_extreme_span();
    test_axis_square();
    test_repeated_vertex();
    test_unit_steps();
    test_random_polygons(650);
    test_output_hold_off();

    // phase 2: heavy request gaps, sparse result stalls
    send_idle_pct = 77;
    recv_idle_pct = 9;
    test_random_polygons(650);
    test_sender_pause();

    // phase 3: full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_polygons(650);

    hold_until_results_in();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_edges.size() != 0) begin
      $error("%0d expected edges never arrived", pending_edges.size());
      mismatch_count++;
    end

    $display("Covered %0d vertices, %0d edges checked (%0d closing, %0d zero length)",
             vertices_sent, edges_checked, closing_checked, zero_checked);
    $display("Ran three stall mixes plus a long result hold-off and a mid-polygon pause");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
